// ===== src/bpc_pkg.sv =====
package bpc_pkg;

    typedef enum logic [2:0] {
        REG_P1    = 3'd0,
        REG_P2    = 3'd1,
        REG_P3    = 3'd2,
        REG_P4    = 3'd3,
        REG_P5    = 3'd4,
        REG_P6    = 3'd5,
        REG_P7    = 3'd6,
        REG_P8_P9 = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } cal_t;

    typedef struct packed {
        logic signed [31:0] pressure;
        logic               zero;
    } result_t;

    localparam logic signed [21:0] TEMP_BIAS = 22'sd128000;
    localparam logic        [20:0] PRES_FULL = 21'd1048576;
    localparam logic signed [51:0] DIV_BIAS  = 52'sh0_8000_0000_0000;
    localparam logic signed [12:0] SCALE     = 13'sd3125;

    localparam int NMAG_W     = 68;
    localparam int DMAG_W     = 33;
    localparam int DIV_STAGES = NMAG_W;

    localparam logic signed [31:0] PA_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] PA_MIN = 32'sh8000_0000;

endpackage

// ===== src/bpc_front.sv =====
module bpc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [20:0]  fine_temp,
    input  logic        [19:0]  raw_pressure,
    input  bpc_pkg::cal_t       cal,
    output logic                out_valid,
    output logic signed [72:0]  num,
    output logic signed [32:0]  divisor
);
    import bpc_pkg::*;

    logic        [5:0]  valid_reg;
    logic signed [21:0] a_reg, a_next;
    logic        [20:0] pn1_reg, pn1_next, pn2_reg, pn3_reg, pn4_reg;
    logic signed [43:0] sq_reg, sq_next;
    logic signed [37:0] ap5_reg, ap5_next, ap2_reg, ap2_next;
    logic signed [59:0] sqp6_reg, sqp6_next, sqp3_reg, sqp3_next;
    logic signed [37:0] ap5_3_reg, ap2_3_reg;
    logic signed [59:0] off_reg, off_next;
    logic signed [51:0] dsum_reg, dsum_next;
    logic signed [59:0] x_reg, x_next;
    logic signed [68:0] dprod_reg, dprod_next;
    logic signed [72:0] num_reg, num_next;
    logic signed [32:0] div_reg, div_next;

    always_comb
    begin
        a_next     = $signed({fine_temp[20], fine_temp}) - TEMP_BIAS;
        pn1_next   = PRES_FULL - {1'b0, raw_pressure};
        sq_next    = a_reg * a_reg;
        ap5_next   = a_reg * cal.p5;
        ap2_next   = a_reg * cal.p2;
        sqp6_next  = sq_reg * cal.p6;
        sqp3_next  = sq_reg * cal.p3;
        off_next   = sqp6_reg + (ap5_3_reg <<< 17) + (cal.p4 <<< 35);
        dsum_next  = $signed(sqp3_reg[59:8]) + (ap2_3_reg <<< 12) + DIV_BIAS;
        x_next     = ($signed({1'b0, pn4_reg}) <<< 31) - off_reg;
        dprod_next = dsum_reg * $signed({1'b0, cal.p1});
        num_next   = x_reg * SCALE;
        div_next   = $signed(dprod_reg[65:33]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg     <= a_next;
            pn1_reg   <= pn1_next;
            sq_reg    <= sq_next;
            ap5_reg   <= ap5_next;
            ap2_reg   <= ap2_next;
            pn2_reg   <= pn1_reg;
            sqp6_reg  <= sqp6_next;
            sqp3_reg  <= sqp3_next;
            ap5_3_reg <= ap5_reg;
            ap2_3_reg <= ap2_reg;
            pn3_reg   <= pn2_reg;
            off_reg   <= off_next;
            dsum_reg  <= dsum_next;
            pn4_reg   <= pn3_reg;
            x_reg     <= x_next;
            dprod_reg <= dprod_next;
            num_reg   <= num_next;
            div_reg   <= div_next;
        end
    end

    assign out_valid = valid_reg[5];
    assign num       = num_reg;
    assign divisor   = div_reg;

endmodule

// ===== src/bpc_div.sv =====
module bpc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [72:0]          num,
    input  logic signed [32:0]          divisor,
    output logic                        out_valid,
    output logic [bpc_pkg::NMAG_W-1:0]  quot,
    output logic                        neg,
    output logic                        zero
);
    import bpc_pkg::*;

    logic signed [72:0]  nabs;
    logic [NMAG_W-1:0]   nmag_reg, nmag_next;
    logic [DMAG_W-1:0]   dmag_reg, dmag_next;
    logic                neg_reg, zero_reg, prep_valid_reg;

    logic [DMAG_W-1:0]   rem_reg  [DIV_STAGES];
    logic [DMAG_W-1:0]   rem_next [DIV_STAGES];
    logic [NMAG_W-1:0]   nq_reg   [DIV_STAGES];
    logic [NMAG_W-1:0]   nq_next  [DIV_STAGES];
    logic [DMAG_W-1:0]   dm_reg   [DIV_STAGES];
    logic [DIV_STAGES-1:0] sgn_reg, zf_reg, valid_reg;

    always_comb
    begin
        nabs      = num[72] ? -num : num;
        nmag_next = nabs[NMAG_W-1:0];
        dmag_next = divisor[32] ? (~divisor + 1'b1) : divisor;
    end

    // One quotient bit per stage, restoring form.
    always_comb
    begin
        logic [DMAG_W-1:0] rem_prev, dm_prev;
        logic [NMAG_W-1:0] nq_prev;
        logic [DMAG_W:0]   trial, diff;
        logic              take;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            rem_prev = (k == 0) ? '0 : rem_reg[(k == 0) ? 0 : k - 1];
            nq_prev  = (k == 0) ? nmag_reg : nq_reg[(k == 0) ? 0 : k - 1];
            dm_prev  = (k == 0) ? dmag_reg : dm_reg[(k == 0) ? 0 : k - 1];
            trial    = {rem_prev, nq_prev[NMAG_W-1]};
            diff     = trial - {1'b0, dm_prev};
            take     = (trial >= {1'b0, dm_prev});
            rem_next[k] = take ? diff[DMAG_W-1:0] : trial[DMAG_W-1:0];
            nq_next[k]  = {nq_prev[NMAG_W-2:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
            valid_reg      <= '0;
        end
        else if (en)
        begin
            prep_valid_reg <= in_valid;
            valid_reg      <= {valid_reg[DIV_STAGES-2:0], prep_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag_reg <= nmag_next;
            dmag_reg <= dmag_next;
            neg_reg  <= num[72] ^ divisor[32];
            zero_reg <= (divisor == '0);
            sgn_reg  <= {sgn_reg[DIV_STAGES-2:0], neg_reg};
            zf_reg   <= {zf_reg[DIV_STAGES-2:0], zero_reg};
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                nq_reg[k]  <= nq_next[k];
                dm_reg[k]  <= (k == 0) ? dmag_reg : dm_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign quot      = nq_reg[DIV_STAGES-1];
    assign neg       = sgn_reg[DIV_STAGES-1];
    assign zero      = zf_reg[DIV_STAGES-1];

endmodule

// ===== src/bpc_back.sv =====
module bpc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [bpc_pkg::NMAG_W-1:0]  quot,
    input  logic                        neg,
    input  logic                        zero,
    input  bpc_pkg::cal_t               cal,
    output logic                        out_valid,
    output bpc_pkg::result_t            result
);
    import bpc_pkg::*;

    logic [8:0]          valid_reg;
    logic [7:0]          zf_reg;
    logic signed [68:0]  p_reg, p_next, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [55:0]  q13, q13_reg;
    logic signed [71:0]  p9q_reg, p9q_next;
    logic signed [84:0]  t2f_reg, t2f_next;
    logic        [35:0]  l1;
    logic signed [35:0]  h1;
    logic        [27:0]  l2;
    logic signed [27:0]  h2;
    logic signed [65:0]  ll_reg, ll_next;
    logic signed [64:0]  lh_reg, lh_next, hl_reg, hl_next;
    logic signed [63:0]  hh_reg, hh_next;
    logic signed [65:0]  t2_3_reg, t2_4_reg, t2_5_reg;
    logic signed [93:0]  suma_reg, suma_next;
    logic signed [92:0]  sumb_reg, sumb_next;
    logic signed [129:0] t1f_reg, t1f_next;
    logic signed [105:0] s_reg, s_next;
    logic signed [98:0]  r_reg, r_next;
    logic signed [91:0]  res_reg, res_next;
    result_t             out_reg, out_next;

    always_comb
    begin
        p_next    = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        q13       = $signed(p_reg[68:13]);
        p9q_next  = cal.p9 * q13;
        t2f_next  = cal.p8 * p_reg;
        l1        = p9q_reg[35:0];
        h1        = $signed(p9q_reg[71:36]);
        l2        = q13_reg[27:0];
        h2        = $signed(q13_reg[55:28]);
        ll_next   = $signed({1'b0, l1}) * $signed({1'b0, l2});
        lh_next   = $signed({1'b0, l1}) * h2;
        hl_next   = h1 * $signed({1'b0, l2});
        hh_next   = h1 * h2;
        suma_next = ll_reg + (lh_reg <<< 28);
        sumb_next = hl_reg + (hh_reg <<< 28);
        t1f_next  = suma_reg + (sumb_reg <<< 36);
        s_next    = p5_reg + $signed(t1f_reg[129:25]) + t2_5_reg;
        r_next    = $signed(s_reg[105:8]) + (cal.p7 <<< 4);
        // Division by 256 rounds toward zero.
        res_next  = $signed(r_reg[98:8])
                  + $signed({91'd0, r_reg[98] && (r_reg[7:0] != 8'd0)});
        out_next.zero = zf_reg[7];
        if (zf_reg[7])
        begin
            out_next.pressure = '0;
        end
        else if (res_reg > PA_MAX)
        begin
            out_next.pressure = PA_MAX;
        end
        else if (res_reg < PA_MIN)
        begin
            out_next.pressure = PA_MIN;
        end
        else
        begin
            out_next.pressure = $signed(res_reg[31:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[7:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zf_reg   <= {zf_reg[6:0], zero};
            p_reg    <= p_next;
            p9q_reg  <= p9q_next;
            t2f_reg  <= t2f_next;
            q13_reg  <= q13;
            p2_reg   <= p_reg;
            ll_reg   <= ll_next;
            lh_reg   <= lh_next;
            hl_reg   <= hl_next;
            hh_reg   <= hh_next;
            p3_reg   <= p2_reg;
            t2_3_reg <= $signed(t2f_reg[84:19]);
            suma_reg <= suma_next;
            sumb_reg <= sumb_next;
            p4_reg   <= p3_reg;
            t2_4_reg <= t2_3_reg;
            t1f_reg  <= t1f_next;
            p5_reg   <= p4_reg;
            t2_5_reg <= t2_4_reg;
            s_reg    <= s_next;
            r_reg    <= r_next;
            res_reg  <= res_next;
            out_reg  <= out_next;
        end
    end

    assign out_valid = valid_reg[8];
    assign result    = out_reg;

endmodule

// ===== src/baro_pressure_compensation_core.sv =====
// Integer barometric pressure compensation. Each word carries a fine
// temperature and a raw 20-bit pressure sample and yields one pressure in
// whole pascals, saturated to signed 32 bits, with a flag when the divisor
// is zero. The datapath is a fixed pipeline: six stages of polynomial terms,
// a 69-stage divider with one stage that takes the magnitudes and 68 that
// each resolve one quotient bit, and nine stages of correction terms and
// saturation. A new word is taken every cycle while the pipeline is not
// halted; a two-word output buffer lets the pipeline keep moving while a
// result waits, and the pipeline halts only when that buffer is full, a
// further result is ready to enter it and the consumer stalls.
// Calibration must be written through the register port only while no
// word is in flight; the core itself does not enforce this.
module baro_pressure_compensation_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  bpc_pkg::cfg_index_t  cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic signed [20:0]   fine_temp,
    input  logic        [19:0]   raw_pressure,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic signed [31:0]   pressure_pa,
    output logic                 zero_divisor
);
    import bpc_pkg::*;

    cal_t               cal_reg, cal_next;
    logic               en, push, pop;
    logic               front_valid, div_valid, back_valid;
    logic signed [72:0] num;
    logic signed [32:0] divisor;
    logic [NMAG_W-1:0]  quot;
    logic               quot_neg, quot_zero;
    result_t            back_result;
    result_t            buf_mem [2];
    logic               wr_ptr_reg, rd_ptr_reg;
    logic [1:0]         count_reg, count_next;

    always_comb
    begin
        cal_next = cal_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_P1:    cal_next.p1 = cfg_data[15:0];
                REG_P2:    cal_next.p2 = $signed(cfg_data[15:0]);
                REG_P3:    cal_next.p3 = $signed(cfg_data[15:0]);
                REG_P4:    cal_next.p4 = $signed(cfg_data[15:0]);
                REG_P5:    cal_next.p5 = $signed(cfg_data[15:0]);
                REG_P6:    cal_next.p6 = $signed(cfg_data[15:0]);
                REG_P7:    cal_next.p7 = $signed(cfg_data[15:0]);
                REG_P8_P9:
                begin
                    cal_next.p8 = $signed(cfg_data[15:0]);
                    cal_next.p9 = $signed(cfg_data[31:16]);
                end
                default:   cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    assign pop  = result_valid && result_ready;
    assign en   = !back_valid || (count_reg != 2'd2) || result_ready;
    assign push = back_valid && en;
    assign item_ready = en;

    bpc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (item_valid),
        .fine_temp    (fine_temp),
        .raw_pressure (raw_pressure),
        .cal          (cal_reg),
        .out_valid    (front_valid),
        .num          (num),
        .divisor      (divisor)
    );

    bpc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .num       (num),
        .divisor   (divisor),
        .out_valid (div_valid),
        .quot      (quot),
        .neg       (quot_neg),
        .zero      (quot_zero)
    );

    bpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .quot      (quot),
        .neg       (quot_neg),
        .zero      (quot_zero),
        .cal       (cal_reg),
        .out_valid (back_valid),
        .result    (back_result)
    );

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_mem[wr_ptr_reg] <= back_result;
        end
    end

    assign result_valid = (count_reg != 2'd0);
    assign pressure_pa  = buf_mem[rd_ptr_reg].pressure;
    assign zero_divisor = buf_mem[rd_ptr_reg].zero;

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && zero_divisor |-> pressure_pa == 32'sd0)
        else $error("zero divisor word carries a nonzero pressure");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        back_valid && (count_reg == 2'd2) && !result_ready |-> !item_ready)
        else $error("pipeline advanced into a full output buffer");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("output buffer count lost a word");

endmodule
